// File: rtl/spq_pkg.sv
package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int VALUE_BITS    = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_BITS   = 2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic                     mode;
    logic [VALUE_BITS-1:0]    entry_value;
    logic [PRIORITY_BITS-1:0] entry_priority;
  } item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [VALUE_BITS-1:0]    out_value;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [COUNT_BITS-1:0]    occupancy;
  } result_t;

  // one queue slot as it moves between neighboring cells
  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } slot_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell (
  input  logic           clk,
  input  logic           en,
  input  spq_pkg::item_t item,
  input  logic           occupied,
  input  logic           left_ge,
  input  spq_pkg::slot_t left,
  input  spq_pkg::slot_t right,
  output spq_pkg::slot_t slot,
  output logic           ge
);
  import spq_pkg::*;

  slot_t slot_next;

  // this slot stays ahead of the new entry (ties keep arrival order)
  assign ge = occupied && (slot.prio >= item.entry_priority);

  always_comb begin
    slot_next = slot;
    if (item.mode == MODE_DEQ) begin
      slot_next = right;
    end else if (!ge) begin
      if (left_ge) begin
        slot_next.value = item.entry_value;
        slot_next.prio  = item.entry_priority;
      end else begin
        slot_next = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot <= slot_next;
    end
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// Channel   Direction  Payload              Handshake
// item      in         spq_pkg::item_t      item_valid / item_stall
// result    out        spq_pkg::result_t    result_valid / result_stall
//
// One item per cycle while item_stall is low: the whole row of cells
// shifts or inserts in the cycle of the transfer, and the result lands
// in the output register in the cycle after the item transfer.
// rst clears the entry count and the output valid; slot contents are
// left as they are and are never read past the count.
// item_stall is high only while a finished result waits under result_stall.
module sorted_priority_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  spq_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output spq_pkg::result_t result
);
  import spq_pkg::*;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  result_t               result_next;

  logic accept;
  logic full;
  logic empty;
  logic cell_en;

  // cell outputs; index QUEUE_DEPTH is a dummy right neighbor of the tail
  slot_t slots [QUEUE_DEPTH+1];
  logic  ges   [QUEUE_DEPTH];

  // The output register parts the two sides: a new item enters while the
  // output is empty or being drained in the same cycle.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign full  = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // Rejected items (full on enqueue, empty on dequeue) leave the row alone.
  assign cell_en = accept && ((item.mode == MODE_ENQ) ? !full : !empty);

  assign slots[QUEUE_DEPTH] = '0;

  // Each cell i decides from its own slot and its left neighbor: keep,
  // take the new entry, take the left slot (insert shift) or the right
  // slot (dequeue shift). Cell 0 sees an always-ahead left neighbor.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic  left_ge;
    slot_t left;

    if (i == 0) begin : g_head
      assign left_ge = 1'b1;
      assign left    = slots[0];
    end else begin : g_body
      assign left_ge = ges[i-1];
      assign left    = slots[i-1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .en       (cell_en),
      .item     (item),
      .occupied (count > COUNT_BITS'(i)),
      .left_ge  (left_ge),
      .left     (left),
      .right    (slots[i+1]),
      .slot     (slots[i]),
      .ge       (ges[i])
    );
  end

  always_comb begin
    count_next  = count;
    result_next = '0;
    if (item.mode == MODE_ENQ) begin
      if (full) begin
        result_next.status = ST_FULL;
      end else begin
        count_next         = count + 1'b1;
        result_next.status = ST_ENQUEUED;
      end
    end else begin
      if (empty) begin
        result_next.status = ST_EMPTY;
      end else begin
        count_next               = count - 1'b1;
        result_next.status       = ST_DEQUEUED;
        result_next.out_value    = slots[0].value;
        result_next.out_priority = slots[0].prio;
      end
    end
    result_next.occupancy = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("transfer gave no result");

  a_occupancy_tracks : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.occupancy == count))
    else $error("reported occupancy differs from entry count");

  a_empty_flag : assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode == MODE_DEQ && empty) |=> (result.status == ST_EMPTY))
    else $error("dequeue on empty queue not flagged");

endmodule
